### rtl/i2cbb_pkg.sv
// ----------------------------------------------------------------------------
// i2cbb_pkg
// Shared types and constants of the I2C bit-bang master: command codes,
// field widths, the queued tick item and the queue head seen by the engine.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned BIT_IDX_W = $clog2(BYTE_BITS) + 1;
  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned WAIT_W    = TICKS_W + 1;
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(16);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } i2cbb_op_t;

  typedef struct packed {
    logic                 cmd_valid;
    logic [1:0]           operation;
    logic [BYTE_BITS-1:0] tx_byte;
    logic                 master_ack;
    logic                 sda_in;
  } i2cbb_item_t;

  typedef struct packed {
    logic        valid;
    i2cbb_item_t item;
  } i2cbb_head_t;

endpackage

### rtl/i2cbb_if.sv
// ----------------------------------------------------------------------------
// i2cbb_in_if / i2cbb_out_if
// Valid/ready channels of the I2C bit-bang master: one tick request in,
// one line and status snapshot out.
// ----------------------------------------------------------------------------
interface i2cbb_in_if
  import i2cbb_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 cmd_valid;
  logic [1:0]           operation;
  logic [BYTE_BITS-1:0] tx_byte;
  logic                 master_ack;
  logic                 sda_in;

  modport source (output valid, output cmd_valid, output operation, output tx_byte,
                  output master_ack, output sda_in, input ready);
  modport sink   (input valid, input cmd_valid, input operation, input tx_byte,
                  input master_ack, input sda_in, output ready);
endinterface

interface i2cbb_out_if
  import i2cbb_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 scl;
  logic                 sda_out;
  logic                 sda_oe;
  logic                 busy_res;
  logic                 done_res;
  logic [BYTE_BITS-1:0] rx_byte;
  logic                 slave_ack;

  modport source (output valid, output scl, output sda_out, output sda_oe,
                  output busy_res, output done_res, output rx_byte,
                  output slave_ack, input ready);
  modport sink   (input valid, input scl, input sda_out, input sda_oe,
                  input busy_res, input done_res, input rx_byte,
                  input slave_ack, output ready);
endinterface

### rtl/i2c_bit_bang_master_unit.sv
// ----------------------------------------------------------------------------
// i2c_bit_bang_master_unit
// I2C master line sequencer driven one clock tick per request.
//
// in_ch carries one tick per request: sampled SDA plus an optional command
// (start, stop, write byte, read byte), taken only while the sequencer idles.
// out_ch returns exactly one snapshot per request: SCL, SDA level and enable,
// busy and done flags, the last read byte and the last write ACK.
// cfg_we / cfg_wdata set phase_ticks, the ticks per bus delay unit.
// Requests enter a two-entry queue; the engine steps once per request and
// holds the snapshot in an output register. An accepted request passes the
// queue entry and then the output register before out_ch can take it; one
// request per cycle is sustained while out_ch.ready stays high.
// When out_ch stalls, the snapshot holds and the queue fills up to its two
// entries before in_ch.ready drops.
// Reset is synchronous: SCL, SDA and SDA enable go high, the sequencer idles,
// results clear, the queue empties and phase_ticks returns to 16.
// ----------------------------------------------------------------------------
module i2c_bit_bang_master_unit
  import i2cbb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [TICKS_W-1:0] cfg_wdata,
  i2cbb_in_if.sink           in_ch,
  i2cbb_out_if.source        out_ch
);

  i2cbb_head_t head;
  logic        pop;

  i2cbb_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .head  (head),
    .pop   (pop)
  );

  i2cbb_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.done_res |-> !out_ch.busy_res)
    else $error("done reported while sequencer still busy");

  a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.sda_oe |-> out_ch.busy_res)
    else $error("SDA released while sequencer idle");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> $past(out_ch.valid && !out_ch.ready))
    else $error("queue filled without an output stall");

endmodule

### rtl/i2cbb_front.sv
// ----------------------------------------------------------------------------
// i2cbb_front
// Input side: accepts tick requests and holds them in a short queue until
// the sequencer engine takes them.
// ----------------------------------------------------------------------------
module i2cbb_front
  import i2cbb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  i2cbb_in_if.sink     in_ch,
  output i2cbb_head_t  head,
  input  logic         pop
);

  i2cbb_item_t          q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 push;
  i2cbb_item_t          item;

  assign in_ch.ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  assign item.cmd_valid  = in_ch.cmd_valid;
  assign item.operation  = in_ch.operation;
  assign item.tx_byte    = in_ch.tx_byte;
  assign item.master_ack = in_ch.master_ack;
  assign item.sda_in     = in_ch.sda_in;

  assign head.valid = (count_r != '0);
  assign head.item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

endmodule

### rtl/i2cbb_engine.sv
// ----------------------------------------------------------------------------
// i2cbb_engine
// Back side: steps the bus sequencer once per queued tick and holds the
// resulting line and status snapshot until the receiver takes it.
// ----------------------------------------------------------------------------
module i2cbb_engine
  import i2cbb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [TICKS_W-1:0] cfg_wdata,
  input  i2cbb_head_t        head,
  output logic               pop,
  i2cbb_out_if.source        out_ch
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_A,
    PH_ST_B,
    PH_SP_A,
    PH_SP_B,
    PH_WR_LOW,
    PH_WR_HIGH,
    PH_WR_ACKLOW,
    PH_WR_ACKHIGH,
    PH_RD_LOW,
    PH_RD_HIGH,
    PH_RD_ACKLOW,
    PH_RD_ACKHIGH
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [BIT_IDX_W-1:0]   bit_idx_r, bit_idx_nxt;
  logic [BYTE_BITS-1:0]   shift_r, shift_nxt;
  logic [WAIT_W-1:0]      wait_r, wait_nxt;
  logic                   ack_choice_r, ack_choice_nxt;
  logic                   scl_r, scl_nxt;
  logic                   sda_r, sda_nxt;
  logic                   oe_r, oe_nxt;
  logic [BYTE_BITS-1:0]   rx_r, rx_nxt;
  logic                   sack_r, sack_nxt;
  logic                   done_r, done_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [TICKS_W-1:0]     ticks_r;

  logic [TICKS_W-1:0]     unit;
  logic [WAIT_W-1:0]      arm1, arm2, wait_dec;
  logic [BIT_IDX_W-1:0]   bit_inc;
  logic                   step;

  assign step = head.valid && (!out_valid_r || out_ch.ready);
  assign pop  = step;

  assign unit     = (ticks_r == '0) ? TICKS_W'(1) : ticks_r;
  assign arm1     = {1'b0, unit};
  assign arm2     = {unit, 1'b0};
  assign wait_dec = (wait_r != '0) ? wait_r - 1'b1 : wait_r;
  assign bit_inc  = bit_idx_r + 1'b1;

  always_comb begin
    phase_nxt      = phase_r;
    bit_idx_nxt    = bit_idx_r;
    shift_nxt      = shift_r;
    wait_nxt       = wait_r;
    ack_choice_nxt = ack_choice_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    oe_nxt         = oe_r;
    rx_nxt         = rx_r;
    sack_nxt       = sack_r;
    done_nxt       = done_r;
    out_valid_nxt  = out_ch.ready ? 1'b0 : out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
      done_nxt      = 1'b0;
      case (phase_r)
        PH_IDLE: begin
          if (head.item.cmd_valid) begin
            bit_idx_nxt = '0;
            case (i2cbb_op_t'(head.item.operation))
              OP_START: begin
                sda_nxt   = 1'b1;
                scl_nxt   = 1'b1;
                wait_nxt  = arm2;
                phase_nxt = PH_ST_A;
              end
              OP_STOP: begin
                sda_nxt   = 1'b0;
                scl_nxt   = 1'b1;
                wait_nxt  = arm2;
                phase_nxt = PH_SP_A;
              end
              OP_WRITE: begin
                shift_nxt = head.item.tx_byte;
                scl_nxt   = 1'b0;
                sda_nxt   = head.item.tx_byte[BYTE_BITS-1];
                wait_nxt  = arm1;
                phase_nxt = PH_WR_LOW;
              end
              default: begin
                ack_choice_nxt = head.item.master_ack;
                shift_nxt      = '0;
                oe_nxt         = 1'b0;
                scl_nxt        = 1'b0;
                wait_nxt       = arm1;
                phase_nxt      = PH_RD_LOW;
              end
            endcase
          end
        end
        default: begin
          wait_nxt = wait_dec;
          if (wait_dec == '0) begin
            case (phase_r)
              PH_ST_A: begin
                sda_nxt   = 1'b0;
                wait_nxt  = arm2;
                phase_nxt = PH_ST_B;
              end
              PH_ST_B: begin
                scl_nxt   = 1'b0;
                phase_nxt = PH_IDLE;
                done_nxt  = 1'b1;
              end
              PH_SP_A: begin
                sda_nxt   = 1'b1;
                wait_nxt  = arm2;
                phase_nxt = PH_SP_B;
              end
              PH_WR_LOW: begin
                scl_nxt   = 1'b1;
                wait_nxt  = arm1;
                phase_nxt = PH_WR_HIGH;
              end
              PH_WR_HIGH: begin
                scl_nxt     = 1'b0;
                shift_nxt   = {shift_r[BYTE_BITS-2:0], 1'b0};
                bit_idx_nxt = bit_inc;
                wait_nxt    = arm1;
                if (bit_inc < BIT_IDX_W'(BYTE_BITS)) begin
                  sda_nxt   = shift_r[BYTE_BITS-2];
                  phase_nxt = PH_WR_LOW;
                end else begin
                  oe_nxt    = 1'b0;
                  phase_nxt = PH_WR_ACKLOW;
                end
              end
              PH_WR_ACKLOW: begin
                scl_nxt   = 1'b1;
                wait_nxt  = arm1;
                phase_nxt = PH_WR_ACKHIGH;
              end
              PH_WR_ACKHIGH: begin
                sack_nxt  = !head.item.sda_in;
                scl_nxt   = 1'b0;
                oe_nxt    = 1'b1;
                phase_nxt = PH_IDLE;
                done_nxt  = 1'b1;
              end
              PH_RD_LOW: begin
                scl_nxt   = 1'b1;
                wait_nxt  = arm1;
                phase_nxt = PH_RD_HIGH;
              end
              PH_RD_HIGH: begin
                shift_nxt   = {shift_r[BYTE_BITS-2:0], head.item.sda_in};
                scl_nxt     = 1'b0;
                bit_idx_nxt = bit_inc;
                wait_nxt    = arm1;
                if (bit_inc < BIT_IDX_W'(BYTE_BITS)) begin
                  phase_nxt = PH_RD_LOW;
                end else begin
                  oe_nxt    = 1'b1;
                  sda_nxt   = !ack_choice_r;
                  phase_nxt = PH_RD_ACKLOW;
                end
              end
              PH_RD_ACKLOW: begin
                scl_nxt   = 1'b1;
                wait_nxt  = arm1;
                phase_nxt = PH_RD_ACKHIGH;
              end
              PH_RD_ACKHIGH: begin
                scl_nxt   = 1'b0;
                sda_nxt   = 1'b1;
                rx_nxt    = shift_r;
                phase_nxt = PH_IDLE;
                done_nxt  = 1'b1;
              end
              default: begin
                phase_nxt = PH_IDLE;
                done_nxt  = 1'b1;
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_idx_r    <= '0;
      shift_r      <= '0;
      wait_r       <= '0;
      ack_choice_r <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      oe_r         <= 1'b1;
      rx_r         <= '0;
      sack_r       <= 1'b0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      ticks_r      <= TICKS_RESET;
    end else begin
      phase_r      <= phase_nxt;
      bit_idx_r    <= bit_idx_nxt;
      shift_r      <= shift_nxt;
      wait_r       <= wait_nxt;
      ack_choice_r <= ack_choice_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      oe_r         <= oe_nxt;
      rx_r         <= rx_nxt;
      sack_r       <= sack_nxt;
      done_r       <= done_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        ticks_r <= cfg_wdata;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.scl       = scl_r;
  assign out_ch.sda_out   = sda_r;
  assign out_ch.sda_oe    = oe_r;
  assign out_ch.busy_res  = (phase_r != PH_IDLE);
  assign out_ch.done_res  = done_r;
  assign out_ch.rx_byte   = rx_r;
  assign out_ch.slave_ack = sack_r;

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the I2C bit-bang master unit. Sends one tick request per
// cycle-slot with random gaps, predicts every line and status snapshot with
// an in-bench model or a typed table row, and checks each returned snapshot in
// order. A short table of commands runs first, then random bus transactions
// across several phase_ticks settings, the smallest and the largest included.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cbb_pkg::*;

  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned DIR_ROWS   = 14;
  localparam int unsigned RAND_PHASES = 7;

  typedef enum logic [4:0] {
    SEQ_IDLE, SEQ_START_A, SEQ_START_B, SEQ_STOP_A, SEQ_STOP_B,
    SEQ_WR_LOW, SEQ_WR_HIGH, SEQ_WR_ACK_LOW, SEQ_WR_ACK_HIGH,
    SEQ_RD_LOW, SEQ_RD_HIGH, SEQ_RD_ACK_LOW, SEQ_RD_ACK_HIGH
  } seq_t;

  typedef struct packed {
    logic                 scl;
    logic                 sda_out;
    logic                 sda_oe;
    logic                 busy_res;
    logic                 done_res;
    logic [BYTE_BITS-1:0] rx_byte;
    logic                 slave_ack;
  } line_snap_t;

  typedef struct packed {
    logic                 cmd_valid;
    i2cbb_op_t            op;
    logic [BYTE_BITS-1:0] tx;
    logic                 mack;
    logic                 sda;
    logic                 noise;
    logic                 typed;
    line_snap_t           want;
  } cmd_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [TICKS_W-1:0] cfg_wdata;

  i2cbb_in_if  in_ch ();
  i2cbb_out_if out_ch ();

  i2c_bit_bang_master_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // sequencer model state
  logic [TICKS_W-1:0]   unit_ticks;
  seq_t                 seq;
  logic [3:0]           bit_cnt;
  logic [BYTE_BITS-1:0] shreg;
  logic [WAIT_W-1:0]    wait_left;
  logic                 ack_sel;
  logic                 line_scl, line_sda, line_oe;
  logic [BYTE_BITS-1:0] last_rx;
  logic                 last_ack;

  line_snap_t pending_snaps [$];
  int         errors;
  int         snaps_checked;
  int         cmds_done;
  int         settings_used;
  bit         quiet;
  bit         bus_open;
  cmd_row_t   plan [DIR_ROWS];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int draw_gap();
    return quiet ? 0 : int'($urandom_range(0, 11));
  endfunction

  function automatic void arm_wait(int unsigned units, seq_t nxt);
    logic [31:0] prod;
    prod      = units * ((unit_ticks == '0) ? 32'd1 : 32'(unit_ticks));
    wait_left = prod[WAIT_W-1:0];
    seq       = nxt;
  endfunction

  function automatic void load_bit();
    line_scl = 1'b0;
    line_sda = shreg[BYTE_BITS-1];
    arm_wait(1, SEQ_WR_LOW);
  endfunction

  function automatic line_snap_t step_sequencer(i2cbb_item_t it);
    line_snap_t r;
    logic       fin;
    fin = 1'b0;
    if (seq == SEQ_IDLE) begin
      if (it.cmd_valid) begin
        bit_cnt = '0;
        case (i2cbb_op_t'(it.operation))
          OP_START: begin
            line_sda = 1'b1;
            line_scl = 1'b1;
            arm_wait(2, SEQ_START_A);
          end
          OP_STOP: begin
            line_sda = 1'b0;
            line_scl = 1'b1;
            arm_wait(2, SEQ_STOP_A);
          end
          OP_WRITE: begin
            shreg = it.tx_byte;
            load_bit();
          end
          default: begin
            ack_sel  = it.master_ack;
            shreg    = '0;
            line_oe  = 1'b0;
            line_scl = 1'b0;
            arm_wait(1, SEQ_RD_LOW);
          end
        endcase
      end
    end else begin
      if (wait_left != '0) wait_left = wait_left - 1'b1;
      if (wait_left == '0) begin
        case (seq)
          SEQ_START_A: begin
            line_sda = 1'b0;
            arm_wait(2, SEQ_START_B);
          end
          SEQ_START_B: begin
            line_scl = 1'b0;
            fin = 1'b1;
          end
          SEQ_STOP_A: begin
            line_sda = 1'b1;
            arm_wait(2, SEQ_STOP_B);
          end
          SEQ_WR_LOW: begin
            line_scl = 1'b1;
            arm_wait(1, SEQ_WR_HIGH);
          end
          SEQ_WR_HIGH: begin
            line_scl = 1'b0;
            shreg    = {shreg[BYTE_BITS-2:0], 1'b0};
            bit_cnt  = bit_cnt + 1'b1;
            if (bit_cnt < BYTE_BITS) begin
              load_bit();
            end else begin
              line_oe = 1'b0;
              arm_wait(1, SEQ_WR_ACK_LOW);
            end
          end
          SEQ_WR_ACK_LOW: begin
            line_scl = 1'b1;
            arm_wait(1, SEQ_WR_ACK_HIGH);
          end
          SEQ_WR_ACK_HIGH: begin
            last_ack = !it.sda_in;
            line_scl = 1'b0;
            line_oe  = 1'b1;
            fin = 1'b1;
          end
          SEQ_RD_LOW: begin
            line_scl = 1'b1;
            arm_wait(1, SEQ_RD_HIGH);
          end
          SEQ_RD_HIGH: begin
            shreg    = {shreg[BYTE_BITS-2:0], it.sda_in};
            line_scl = 1'b0;
            bit_cnt  = bit_cnt + 1'b1;
            if (bit_cnt < BYTE_BITS) begin
              arm_wait(1, SEQ_RD_LOW);
            end else begin
              line_oe  = 1'b1;
              line_sda = !ack_sel;
              arm_wait(1, SEQ_RD_ACK_LOW);
            end
          end
          SEQ_RD_ACK_LOW: begin
            line_scl = 1'b1;
            arm_wait(1, SEQ_RD_ACK_HIGH);
          end
          SEQ_RD_ACK_HIGH: begin
            line_scl = 1'b0;
            line_sda = 1'b1;
            last_rx  = shreg;
            fin = 1'b1;
          end
          default: fin = 1'b1;
        endcase
        if (fin) seq = SEQ_IDLE;
      end
    end
    r.scl       = line_scl;
    r.sda_out   = line_sda;
    r.sda_oe    = line_oe;
    r.busy_res  = (seq != SEQ_IDLE);
    r.done_res  = fin;
    r.rx_byte   = last_rx;
    r.slave_ack = last_ack;
    return r;
  endfunction

  // drive one tick request, wait for its acceptance, record the snapshot it owes
  task automatic send_tick(i2cbb_item_t it, bit typed, line_snap_t typed_snap);
    int         gap;
    line_snap_t snap;
    gap = draw_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd_valid  <= it.cmd_valid;
    in_ch.operation  <= it.operation;
    in_ch.tx_byte    <= it.tx_byte;
    in_ch.master_ack <= it.master_ack;
    in_ch.sda_in     <= it.sda_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    snap = step_sequencer(it);
    if (snap.done_res) cmds_done++;
    pending_snaps.push_back(typed ? typed_snap : snap);
  endtask

  task automatic drain_and_set(logic [TICKS_W-1:0] ticks);
    in_ch.valid <= 1'b0;
    while (pending_snaps.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we     <= 1'b0;
    unit_ticks  = ticks;
    settings_used++;
  endtask

  function automatic i2cbb_item_t make_tick();
    i2cbb_item_t it;
    int unsigned pick;
    it.cmd_valid  = 1'b0;
    it.operation  = 2'($urandom_range(0, 3));
    it.tx_byte    = 8'($urandom);
    it.master_ack = 1'($urandom);
    it.sda_in     = 1'($urandom);
    if (seq == SEQ_IDLE) begin
      if ($urandom_range(0, 9) < 8) begin
        it.cmd_valid = 1'b1;
        pick = $urandom_range(0, 99);
        if (!bus_open) begin
          if (pick < 85) it.operation = OP_START;
        end else if (pick < 45) begin
          it.operation = OP_WRITE;
        end else if (pick < 75) begin
          it.operation = OP_READ;
        end else if (pick < 92) begin
          it.operation = OP_STOP;
        end else begin
          it.operation = OP_START;
        end
        if (it.operation == OP_START) bus_open = 1'b1;
        if (it.operation == OP_STOP) bus_open = 1'b0;
      end
    end else begin
      it.cmd_valid = ($urandom_range(0, 9) == 0);
    end
    return it;
  endfunction

  task automatic run_random(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      send_tick(make_tick(), 1'b0, '0);
    end
  endtask

  // result side: random stalls, in-order field check
  initial begin
    int         stall;
    line_snap_t want;
    out_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_snaps.size() == 0) begin
          $error("snapshot returned with no request pending");
          errors++;
        end else begin
          want = pending_snaps.pop_front();
          snaps_checked++;
          if (out_ch.scl !== want.scl) begin
            $error("scl: expected %0d, got %0d", want.scl, out_ch.scl);
            errors++;
          end
          if (out_ch.sda_out !== want.sda_out) begin
            $error("sda_out: expected %0d, got %0d", want.sda_out, out_ch.sda_out);
            errors++;
          end
          if (out_ch.sda_oe !== want.sda_oe) begin
            $error("sda_oe: expected %0d, got %0d", want.sda_oe, out_ch.sda_oe);
            errors++;
          end
          if (out_ch.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, got %0d", want.busy_res, out_ch.busy_res);
            errors++;
          end
          if (out_ch.done_res !== want.done_res) begin
            $error("done_res: expected %0d, got %0d", want.done_res, out_ch.done_res);
            errors++;
          end
          if (out_ch.rx_byte !== want.rx_byte) begin
            $error("rx_byte: expected 0x%02h, got 0x%02h", want.rx_byte, out_ch.rx_byte);
            errors++;
          end
          if (out_ch.slave_ack !== want.slave_ack) begin
            $error("slave_ack: expected %0d, got %0d", want.slave_ack, out_ch.slave_ack);
            errors++;
          end
        end
        stall = draw_gap();
        if (stall != 0) out_ch.ready <= 1'b0;
      end else if (!out_ch.ready) begin
        if (stall > 0) stall--;
        if (stall == 0) out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles", idle_cycles);
          $display("** i2c_bit_bang_master_unit: FAILED **");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [TICKS_W-1:0] rand_ticks [RAND_PHASES];
    i2cbb_item_t        it;
    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.cmd_valid  = 1'b0;
    in_ch.operation  = OP_START;
    in_ch.tx_byte    = '0;
    in_ch.master_ack = 1'b0;
    in_ch.sda_in     = 1'b1;
    errors        = 0;
    snaps_checked = 0;
    cmds_done     = 0;
    settings_used = 1;
    quiet         = 1'b0;
    bus_open      = 1'b0;

    unit_ticks = TICKS_RESET;
    seq        = SEQ_IDLE;
    bit_cnt    = '0;
    shreg      = '0;
    wait_left  = '0;
    ack_sel    = 1'b0;
    line_scl   = 1'b1;
    line_sda   = 1'b1;
    line_oe    = 1'b1;
    last_rx    = '0;
    last_ack   = 1'b0;

    //            cmd  op        tx     mack  sda   noise typed want
    plan[0]  = '{1'b1, OP_START, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1,
                 '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}};
    plan[1]  = '{1'b0, OP_START, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1,
                 '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}};
    plan[2]  = '{1'b1, OP_WRITE, 8'hA5, 1'b0, 1'b0, 1'b0, 1'b0, '0};
    plan[3]  = '{1'b1, OP_WRITE, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0};
    plan[4]  = '{1'b1, OP_WRITE, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, '0};
    plan[5]  = '{1'b1, OP_READ,  8'h00, 1'b1, 1'b1, 1'b0, 1'b0, '0};
    plan[6]  = '{1'b1, OP_READ,  8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, '0};
    plan[7]  = '{1'b1, OP_WRITE, 8'h3C, 1'b0, 1'b0, 1'b1, 1'b0, '0};
    plan[8]  = '{1'b1, OP_READ,  8'h5A, 1'b1, 1'b1, 1'b1, 1'b0, '0};
    plan[9]  = '{1'b1, OP_STOP,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0};
    plan[10] = '{1'b1, OP_STOP,  8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, '0};
    plan[11] = '{1'b1, OP_START, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0};
    plan[12] = '{1'b0, OP_READ,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0};
    plan[13] = '{1'b1, OP_STOP,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0};

    rand_ticks[0] = 16'd1;
    rand_ticks[1] = 16'd0;
    rand_ticks[2] = 16'd2;
    rand_ticks[3] = 16'd3;
    rand_ticks[4] = 16'd1;
    rand_ticks[5] = 16'd4;
    rand_ticks[6] = 16'd7;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // first row runs at the reset setting, the rest at one tick per unit
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (r == 1) drain_and_set(16'd1);
      it.cmd_valid  = plan[r].cmd_valid;
      it.operation  = plan[r].op;
      it.tx_byte    = plan[r].tx;
      it.master_ack = plan[r].mack;
      it.sda_in     = plan[r].sda;
      send_tick(it, plan[r].typed, plan[r].want);
      while (seq != SEQ_IDLE) begin
        it.cmd_valid = plan[r].noise;
        it.operation = 2'($urandom_range(0, 3));
        send_tick(it, 1'b0, '0);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_and_set(rand_ticks[p]);
      run_random(65);
    end

    // widest unit last: the sequencer is still mid-wait when stimulus ends
    drain_and_set(16'hFFFF);
    quiet = 1'b1;
    run_random(30);

    in_ch.valid <= 1'b0;
    while (pending_snaps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("tb: %0d snapshots checked under %0d phase_ticks settings,",
             snaps_checked, settings_used);
    $display("tb: %0d bus commands completed, %0d mismatches", cmds_done, errors);
    if (errors == 0) begin
      $display("** i2c_bit_bang_master_unit: PASSED **");
    end else begin
      $display("** i2c_bit_bang_master_unit: FAILED **");
    end
    $finish;
  end

endmodule
